FILE: design/cts_pkg.sv
// Shared types, constants and keyword tables for the token scanner.
// Used by cts_front, cts_queue, cts_back and c_like_token_scanner.
package cts_pkg;

    // Default configuration values
    localparam int MAX_TOKEN_LEN_DEF = 255;
    localparam int NUM_KEYWORDS_DEF  = 7;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Keyword table size
    localparam int KW_MAX     = 7;
    localparam int KW_CHARS   = 6;

    // Token kinds
    typedef enum logic [4:0] {
        K_STAR    = 5'd0,
        K_PERCENT = 5'd1,
        K_NE      = 5'd2,
        K_LE      = 5'd3,
        K_LT      = 5'd4,
        K_GE      = 5'd5,
        K_GT      = 5'd6,
        K_EQEQ    = 5'd7,
        K_ASSIGN  = 5'd8,
        K_INC     = 5'd9,
        K_PLUS    = 5'd10,
        K_DEC     = 5'd11,
        K_MINUS   = 5'd12,
        K_SYMBOL  = 5'd13,
        K_KEYWORD = 5'd14,
        K_ID      = 5'd15,
        K_NUMBER  = 5'd16,
        K_FLOAT   = 5'd17,
        K_BAD_ID  = 5'd18,
        K_SLASH   = 5'd19
    } t_kind;

    // Keyword text (int, float, if, else, while, return, main), zero padded
    localparam logic [7:0] KW_TEXT [0:KW_MAX-1][0:KW_CHARS-1] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"r", "e", "t", "u", "r", "n"},
        '{"m", "a", "i", "n", 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [0:KW_MAX-1] = '{
        3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd6, 3'd4
    };

    // One input request
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    // One result request
    typedef struct packed {
        logic [4:0] token_kind;
        logic [7:0] symbol_char;
        logic [2:0] keyword_index;
        logic [7:0] token_length;
        logic       last_result;
    } t_out_item;

    // Results caused by one input request: one or two
    typedef struct packed {
        logic      two;
        t_out_item r0;
        t_out_item r1;
    } t_entry;

endpackage

FILE: design/cts_front.sv
// Front end of the token scanner: DFA state, keyword candidates and token
// classification for one character per accepted cycle. Depends on cts_pkg.
module cts_front
    import cts_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int NUM_KEYWORDS  = NUM_KEYWORDS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_entry   o_entry
);

    localparam logic [7:0]        LEN_MAX = 8'(MAX_TOKEN_LEN);
    localparam logic [KW_MAX-1:0] KW_INIT = KW_MAX'((2 ** NUM_KEYWORDS) - 1);

    // One-hot scanner states
    typedef enum logic [11:0] {
        ST_START   = 12'b0000_0000_0001,
        ST_LT      = 12'b0000_0000_0010,
        ST_GT      = 12'b0000_0000_0100,
        ST_EQ      = 12'b0000_0000_1000,
        ST_PLUS    = 12'b0000_0001_0000,
        ST_MINUS   = 12'b0000_0010_0000,
        ST_ID      = 12'b0000_0100_0000,
        ST_NUM     = 12'b0000_1000_0000,
        ST_FLOAT   = 12'b0001_0000_0000,
        ST_BAD     = 12'b0010_0000_0000,
        ST_SLASH   = 12'b0100_0000_0000,
        ST_COMMENT = 12'b1000_0000_0000
    } t_scan_state;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v < LEN_MAX) ? v + 8'd1 : LEN_MAX;
    endfunction

    // Keep keyword candidates whose character at pos matches c
    function automatic logic [KW_MAX-1:0] narrow(input logic [KW_MAX-1:0] cand,
                                                 input logic [7:0] pos,
                                                 input logic [7:0] c);
        logic [KW_MAX-1:0] keep;
        keep = '0;
        for (int k = 0; k < KW_MAX; k++) begin
            if (k < NUM_KEYWORDS && cand[k] && pos < {5'd0, KW_LEN[k]} &&
                KW_TEXT[k][pos[2:0]] == c) begin
                keep[k] = 1'b1;
            end
        end
        return keep;
    endfunction

    function automatic t_out_item mk(input t_kind kind, input logic [7:0] sym,
                                     input logic [2:0] kw, input logic [7:0] len);
        t_out_item r;
        r.token_kind    = kind;
        r.symbol_char   = sym;
        r.keyword_index = kw;
        r.token_length  = len;
        r.last_result   = 1'b0;
        return r;
    endfunction

    t_scan_state       r_state, n_state;
    logic [7:0]        r_wlen, n_wlen;
    logic [KW_MAX-1:0] r_cand, n_cand;

    logic [7:0]        c;
    logic              f_valid, s_valid, d_valid, done;
    t_out_item         f_item, s_item, d_item;
    t_scan_state       s_state;
    logic [7:0]        s_wlen;
    logic [KW_MAX-1:0] s_cand;
    logic [1:0]        cnt;
    t_out_item         slot0, slot1;

    assign c = i_item.char_code;

    // Flush: token held by the current state
    always_comb begin
        logic       kw_hit;
        logic [2:0] kw_idx;
        kw_hit = 1'b0;
        kw_idx = 3'd0;
        for (int k = KW_MAX - 1; k >= 0; k--) begin
            if (r_cand[k] && r_wlen == {5'd0, KW_LEN[k]}) begin
                kw_hit = 1'b1;
                kw_idx = 3'(k);
            end
        end
        f_valid = 1'b1;
        f_item  = mk(K_LT, 8'd0, 3'd0, 8'd1);
        case (r_state)
            ST_LT:    f_item = mk(K_LT, 8'd0, 3'd0, 8'd1);
            ST_GT:    f_item = mk(K_GT, 8'd0, 3'd0, 8'd1);
            ST_EQ:    f_item = mk(K_ASSIGN, 8'd0, 3'd0, 8'd1);
            ST_PLUS:  f_item = mk(K_PLUS, 8'd0, 3'd0, 8'd1);
            ST_MINUS: f_item = mk(K_MINUS, 8'd0, 3'd0, 8'd1);
            ST_ID: begin
                if (kw_hit) f_item = mk(K_KEYWORD, 8'd0, kw_idx, r_wlen);
                else        f_item = mk(K_ID, 8'd0, 3'd0, r_wlen);
            end
            ST_NUM:   f_item = mk(K_NUMBER, 8'd0, 3'd0, r_wlen);
            ST_FLOAT: f_item = mk(K_FLOAT, 8'd0, 3'd0, r_wlen);
            ST_BAD:   f_item = mk(K_BAD_ID, 8'd0, 3'd0, r_wlen);
            ST_SLASH: f_item = mk(K_SLASH, 8'd0, 3'd0, 8'd1);
            default:  f_valid = 1'b0;
        endcase
    end

    // Start: classify the character from the start state
    always_comb begin
        s_state = ST_START;
        s_wlen  = r_wlen;
        s_cand  = r_cand;
        s_valid = 1'b0;
        s_item  = mk(K_STAR, 8'd0, 3'd0, 8'd1);
        if (c == "*") begin
            s_valid = 1'b1;
        end else if (c == "%") begin
            s_valid = 1'b1;
            s_item  = mk(K_PERCENT, 8'd0, 3'd0, 8'd1);
        end else if (c == "<") begin
            s_state = ST_LT;
        end else if (c == ">") begin
            s_state = ST_GT;
        end else if (c == "=") begin
            s_state = ST_EQ;
        end else if (c == "+") begin
            s_state = ST_PLUS;
        end else if (c == "-") begin
            s_state = ST_MINUS;
        end else if (is_alpha(c) || c == "_") begin
            s_state = ST_ID;
            s_wlen  = sat_inc(8'd0);
            s_cand  = narrow(KW_INIT, 8'd0, c);
        end else if (is_digit(c)) begin
            s_state = ST_NUM;
            s_wlen  = sat_inc(8'd0);
            s_cand  = '0;
        end else if (c == "/") begin
            s_state = ST_SLASH;
        end else if (c inside {"(", ")", ";", "{", "}", ","}) begin
            s_valid = 1'b1;
            s_item  = mk(K_SYMBOL, c, 3'd0, 8'd1);
        end
    end

    // Advance the DFA for one character
    always_comb begin
        done    = 1'b0;
        d_valid = 1'b0;
        d_item  = mk(K_NE, 8'd0, 3'd0, 8'd2);
        n_state = r_state;
        n_wlen  = r_wlen;
        n_cand  = r_cand;
        case (r_state)
            ST_LT: begin
                if (c == ">") begin
                    done = 1'b1; d_valid = 1'b1; n_state = ST_START;
                end else if (c == "=") begin
                    done = 1'b1; d_valid = 1'b1; n_state = ST_START;
                    d_item = mk(K_LE, 8'd0, 3'd0, 8'd2);
                end
            end
            ST_GT: begin
                if (c == "=") begin
                    done = 1'b1; d_valid = 1'b1; n_state = ST_START;
                    d_item = mk(K_GE, 8'd0, 3'd0, 8'd2);
                end
            end
            ST_EQ: begin
                if (c == "=") begin
                    done = 1'b1; d_valid = 1'b1; n_state = ST_START;
                    d_item = mk(K_EQEQ, 8'd0, 3'd0, 8'd2);
                end
            end
            ST_PLUS: begin
                if (c == "+") begin
                    done = 1'b1; d_valid = 1'b1; n_state = ST_START;
                    d_item = mk(K_INC, 8'd0, 3'd0, 8'd2);
                end
            end
            ST_MINUS: begin
                if (c == "-") begin
                    done = 1'b1; d_valid = 1'b1; n_state = ST_START;
                    d_item = mk(K_DEC, 8'd0, 3'd0, 8'd2);
                end
            end
            ST_ID: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    done   = 1'b1;
                    n_wlen = sat_inc(r_wlen);
                    n_cand = narrow(r_cand, r_wlen, c);
                end
            end
            ST_BAD: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    done   = 1'b1;
                    n_wlen = sat_inc(r_wlen);
                end
            end
            ST_NUM: begin
                if (is_digit(c)) begin
                    done   = 1'b1;
                    n_wlen = sat_inc(r_wlen);
                end else if (is_alpha(c) || c == "_") begin
                    done    = 1'b1;
                    n_state = ST_BAD;
                    n_wlen  = sat_inc(r_wlen);
                end else if (c == ".") begin
                    done    = 1'b1;
                    n_state = ST_FLOAT;
                    n_wlen  = sat_inc(r_wlen);
                end
            end
            ST_FLOAT: begin
                if (is_digit(c)) begin
                    done   = 1'b1;
                    n_wlen = sat_inc(r_wlen);
                end
            end
            ST_SLASH: begin
                if (c == "/") begin
                    done    = 1'b1;
                    n_state = ST_COMMENT;
                end
            end
            ST_COMMENT: begin
                done = 1'b1;
                if (c == 8'h0A) n_state = ST_START;
            end
            default: ;
        endcase

        // End of input drops the character and flushes
        if (i_item.end_of_input) begin
            n_state = ST_START;
            n_wlen  = r_wlen;
            n_cand  = r_cand;
            cnt     = {1'b0, f_valid};
            slot0   = f_item;
            slot1   = s_item;
        end else if (done) begin
            cnt     = {1'b0, d_valid};
            slot0   = d_item;
            slot1   = s_item;
        end else begin
            n_state = s_state;
            n_wlen  = s_wlen;
            n_cand  = s_cand;
            cnt     = 2'({1'b0, f_valid} + {1'b0, s_valid});
            slot0   = f_valid ? f_item : s_item;
            slot1   = s_item;
        end

        // Mark the final result of this character
        if (cnt == 2'd2) slot1.last_result = 1'b1;
        else             slot0.last_result = 1'b1;
    end

    assign o_push        = i_accept && (cnt != 2'd0);
    assign o_entry.two   = (cnt == 2'd2);
    assign o_entry.r0    = slot0;
    assign o_entry.r1    = slot1;

    // Hold scanner state between accepted characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_wlen  <= 8'd0;
            r_cand  <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_wlen  <= n_wlen;
            r_cand  <= n_cand;
        end
    end

    a_eoi_to_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.end_of_input) |=> (r_state == ST_START))
        else $error("scanner not back at start after end of input");

endmodule

FILE: design/cts_queue.sv
// Short queue of result groups between the scanner front end and the
// output stage. Depends on cts_pkg.
module cts_queue
    import cts_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // Store pushed groups
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= ptr_inc(r_wr);
            if (i_pop)  r_rd <= ptr_inc(r_rd);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

FILE: design/cts_back.sv
// Output stage: takes result groups from the queue and presents them one
// request at a time. Depends on cts_pkg.
module cts_back
    import cts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_entry    i_head,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic   r_valid;
    logic   r_idx;
    t_entry r_entry;

    logic   deliver, cur_last, advance;

    assign deliver  = i_pop && r_valid;
    assign cur_last = !r_entry.two || r_idx;
    assign advance  = !r_valid || (deliver && cur_last);
    assign o_q_pop  = advance && !i_q_empty;
    assign o_empty  = !r_valid;
    assign o_item   = r_idx ? r_entry.r1 : r_entry.r0;

    // Load the next group or step to its second result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (advance) begin
            r_valid <= !i_q_empty;
            r_idx   <= 1'b0;
        end else if (deliver) begin
            r_idx   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !i_q_empty) r_entry <= i_head;
    end

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !o_item.last_result) |=> !o_empty)
        else $error("second result of a character lost");

endmodule

FILE: design/c_like_token_scanner.sv
// Token scanner for a small C-like language, one character per request.
// A result request passes through the result queue, written at the
// accepting edge, and the output register, loaded from the queue head.
// Throughput: one character per cycle while not full; a character that
// gives two tokens shows them in turn, the queue absorbs the burst.
// Reset: synchronous, active low; clears scanner state, queue and output.
module c_like_token_scanner
    import cts_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int NUM_KEYWORDS  = NUM_KEYWORDS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic   accept;
    logic   f_push;
    t_entry f_entry;
    logic   q_pop, q_empty;
    t_entry q_head;

    assign accept = push && !full;

    cts_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .NUM_KEYWORDS  (NUM_KEYWORDS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (f_push),
        .o_entry  (f_entry)
    );

    cts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_entry (f_entry),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    cts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_item)
    );

endmodule

FILE: sim/cts_checker.sv
// Scoreboard for the token scanner: predicts the tokens of each accepted
// character request and compares them with the result requests in order.
// Depends on cts_pkg for the request structs and the token kind codes.
module cts_checker
    import cts_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int NUM_KEYWORDS  = NUM_KEYWORDS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_item  i_item,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_item i_result,
    output int        o_errors,
    output int        o_pending,
    output int        o_checked,
    output int        o_double
);

    // Lexer states of the predictor
    typedef enum logic [3:0] {
        SC_START, SC_LT, SC_GT, SC_EQ, SC_PLUS, SC_MINUS, SC_IDENT,
        SC_NUMBER, SC_FLOAT, SC_BADID, SC_SLASH, SC_COMMENT
    } t_scan;

    localparam int KW_COUNT = (NUM_KEYWORDS < 7) ? NUM_KEYWORDS : 7;

    t_scan       lex_state = SC_START;
    logic [7:0]  word_len  = '0;
    logic [6:0]  kw_cand   = '0;
    t_out_item   step_tok [0:1];
    int          step_n;
    t_out_item   token_queue [$];
    int          n_errors  = 0;
    int          n_checked = 0;
    int          n_double  = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
        o_double  = 0;
    end

    // Keyword text, right aligned, first character highest
    function automatic logic [47:0] kw_word(int k);
        case (k)
            0:       return "int";
            1:       return "float";
            2:       return "if";
            3:       return "else";
            4:       return "while";
            5:       return "return";
            default: return "main";
        endcase
    endfunction

    function automatic int kw_size(int k);
        case (k)
            0:       return 3;
            1:       return 5;
            2:       return 2;
            3:       return 4;
            4:       return 5;
            5:       return 6;
            default: return 4;
        endcase
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word(logic [7:0] c);
        return is_letter(c) || is_num(c) || c == "_";
    endfunction

    task automatic emit(t_kind kind, logic [7:0] sym, logic [2:0] kw, logic [7:0] len);
        t_out_item tok;
        tok               = '0;
        tok.token_kind    = kind;
        tok.symbol_char   = sym;
        tok.keyword_index = kw;
        tok.token_length  = len;
        step_tok[step_n]  = tok;
        step_n++;
    endtask

    // Append one character to the pending word and narrow the keyword candidates
    task automatic grow(logic [7:0] c);
        logic [6:0]  keep;
        logic [47:0] w;
        if (lex_state == SC_IDENT) begin
            keep = '0;
            for (int k = 0; k < KW_COUNT; k++) begin
                if (kw_cand[k] && word_len < kw_size(k)) begin
                    w = kw_word(k);
                    if (w[8*(kw_size(k)-1-word_len) +: 8] == c)
                        keep[k] = 1'b1;
                end
            end
            kw_cand = keep;
        end
        word_len = (word_len < MAX_TOKEN_LEN) ? word_len + 8'd1 : 8'(MAX_TOKEN_LEN);
    endtask

    // Emit whatever token the current state holds
    task automatic flush_pending();
        bit found;
        found = 1'b0;
        case (lex_state)
            SC_LT:     emit(K_LT, 8'd0, 3'd0, 8'd1);
            SC_GT:     emit(K_GT, 8'd0, 3'd0, 8'd1);
            SC_EQ:     emit(K_ASSIGN, 8'd0, 3'd0, 8'd1);
            SC_PLUS:   emit(K_PLUS, 8'd0, 3'd0, 8'd1);
            SC_MINUS:  emit(K_MINUS, 8'd0, 3'd0, 8'd1);
            SC_IDENT: begin
                for (int k = 0; k < KW_COUNT; k++) begin
                    if (!found && kw_cand[k] && word_len == kw_size(k)) begin
                        emit(K_KEYWORD, 8'd0, 3'(k), word_len);
                        found = 1'b1;
                    end
                end
                if (!found)
                    emit(K_ID, 8'd0, 3'd0, word_len);
            end
            SC_NUMBER: emit(K_NUMBER, 8'd0, 3'd0, word_len);
            SC_FLOAT:  emit(K_FLOAT, 8'd0, 3'd0, word_len);
            SC_BADID:  emit(K_BAD_ID, 8'd0, 3'd0, word_len);
            SC_SLASH:  emit(K_SLASH, 8'd0, 3'd0, 8'd1);
            default: ;
        endcase
    endtask

    // Handle one character from the start state
    task automatic from_start(logic [7:0] c);
        lex_state = SC_START;
        if (c == "*")
            emit(K_STAR, 8'd0, 3'd0, 8'd1);
        else if (c == "%")
            emit(K_PERCENT, 8'd0, 3'd0, 8'd1);
        else if (c == "<")
            lex_state = SC_LT;
        else if (c == ">")
            lex_state = SC_GT;
        else if (c == "=")
            lex_state = SC_EQ;
        else if (c == "+")
            lex_state = SC_PLUS;
        else if (c == "-")
            lex_state = SC_MINUS;
        else if (is_letter(c) || c == "_") begin
            lex_state = SC_IDENT;
            word_len  = '0;
            kw_cand   = 7'((1 << KW_COUNT) - 1);
            grow(c);
        end else if (is_num(c)) begin
            lex_state = SC_NUMBER;
            word_len  = '0;
            kw_cand   = '0;
            grow(c);
        end else if (c == "/")
            lex_state = SC_SLASH;
        else if (c == "(" || c == ")" || c == ";" || c == "{" || c == "}" || c == ",")
            emit(K_SYMBOL, c, 3'd0, 8'd1);
    endtask

    // Work out the tokens of one character request and queue them
    task automatic predict(t_in_item it);
        logic [7:0] c;
        bit         taken;
        c      = it.char_code;
        taken  = 1'b0;
        step_n = 0;
        if (it.end_of_input) begin
            flush_pending();
            lex_state = SC_START;
        end else begin
            case (lex_state)
                SC_LT: begin
                    if (c == ">") begin
                        emit(K_NE, 8'd0, 3'd0, 8'd2);
                        lex_state = SC_START;
                        taken     = 1'b1;
                    end else if (c == "=") begin
                        emit(K_LE, 8'd0, 3'd0, 8'd2);
                        lex_state = SC_START;
                        taken     = 1'b1;
                    end
                end
                SC_GT: if (c == "=") begin
                    emit(K_GE, 8'd0, 3'd0, 8'd2);
                    lex_state = SC_START;
                    taken     = 1'b1;
                end
                SC_EQ: if (c == "=") begin
                    emit(K_EQEQ, 8'd0, 3'd0, 8'd2);
                    lex_state = SC_START;
                    taken     = 1'b1;
                end
                SC_PLUS: if (c == "+") begin
                    emit(K_INC, 8'd0, 3'd0, 8'd2);
                    lex_state = SC_START;
                    taken     = 1'b1;
                end
                SC_MINUS: if (c == "-") begin
                    emit(K_DEC, 8'd0, 3'd0, 8'd2);
                    lex_state = SC_START;
                    taken     = 1'b1;
                end
                SC_IDENT, SC_BADID: if (is_word(c)) begin
                    grow(c);
                    taken = 1'b1;
                end
                SC_NUMBER: begin
                    if (is_num(c)) begin
                        grow(c);
                        taken = 1'b1;
                    end else if (is_letter(c) || c == "_") begin
                        lex_state = SC_BADID;
                        grow(c);
                        taken = 1'b1;
                    end else if (c == ".") begin
                        lex_state = SC_FLOAT;
                        grow(c);
                        taken = 1'b1;
                    end
                end
                SC_FLOAT: if (is_num(c)) begin
                    grow(c);
                    taken = 1'b1;
                end
                SC_SLASH: if (c == "/") begin
                    lex_state = SC_COMMENT;
                    taken     = 1'b1;
                end
                SC_COMMENT: begin
                    if (c == 8'h0A)
                        lex_state = SC_START;
                    taken = 1'b1;
                end
                default: ;
            endcase
            if (!taken) begin
                flush_pending();
                from_start(c);
            end
        end
        if (step_n > 0)
            step_tok[step_n-1].last_result = 1'b1;
        for (int i = 0; i < step_n; i++)
            token_queue.push_back(step_tok[i]);
        if (step_n == 2)
            n_double++;
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Compare taken results first, then predict from the taken character
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_pop && !i_empty) begin
                if (token_queue.size() == 0) begin
                    $error("unexpected token: kind %0d length %0d",
                           i_result.token_kind, i_result.token_length);
                    n_errors++;
                end else begin
                    want = token_queue.pop_front();
                    check_field("token_kind", 8'(want.token_kind), 8'(i_result.token_kind));
                    check_field("symbol_char", want.symbol_char, i_result.symbol_char);
                    check_field("keyword_index", 8'(want.keyword_index),
                                8'(i_result.keyword_index));
                    check_field("token_length", want.token_length, i_result.token_length);
                    check_field("last_result", 8'(want.last_result),
                                8'(i_result.last_result));
                    n_checked++;
                end
            end
            if (i_push && !i_full)
                predict(i_item);
        end
        o_errors  <= n_errors;
        o_pending <= token_queue.size();
        o_checked <= n_checked;
        o_double  <= n_double;
    end

endmodule

FILE: sim/tb_c_like_token_scanner.sv
// Testbench top for the token scanner: drives character requests and pops
// tokens with random stalls; cts_checker (cts_checker.sv) does the checking.
// Depends on cts_pkg and the c_like_token_scanner RTL.
module tb_c_like_token_scanner;
    import cts_pkg::*;

    localparam int ITEM_TARGET = 1200;
    localparam int QUIET_FROM  = 1000;
    localparam int STALL_LIMIT = 500;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_item;

    int        n_errors;
    int        n_pending;
    int        n_checked;
    int        n_double;
    int        n_sent         = 0;
    bit        quiet          = 1'b0;
    int        send_stall_pct = 10;
    int        pop_stall_pct  = 10;
    int        pop_hold       = 0;
    int        cycle_cnt      = 0;
    int        idle_cycles    = 0;
    logic [7:0] text_buf [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    c_like_token_scanner #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN_DEF),
        .NUM_KEYWORDS  (NUM_KEYWORDS_DEF)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    cts_checker #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN_DEF),
        .NUM_KEYWORDS  (NUM_KEYWORDS_DEF)
    ) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_item    (i_item),
        .i_empty   (empty),
        .i_pop     (pop),
        .i_result  (o_item),
        .o_errors  (n_errors),
        .o_pending (n_pending),
        .o_checked (n_checked),
        .o_double  (n_double)
    );

    // Pop tokens, stalling in random bursts; change the stall rate now and then
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 100 == 0) begin
            case ($urandom_range(0, 3))
                0:       pop_stall_pct <= 0;
                1:       pop_stall_pct <= 4;
                2:       pop_stall_pct <= 15;
                default: pop_stall_pct <= 40;
            endcase
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if (!quiet && $urandom_range(0, 99) < pop_stall_pct) begin
            pop      <= 1'b0;
            pop_hold <= $urandom_range(0, 12);
        end else begin
            pop <= 1'b1;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $error("no request accepted for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Send one character request, after an optional idle burst
    task automatic send_byte(logic [7:0] c, bit eoi);
        int gap;
        if (!quiet && $urandom_range(0, 99) < send_stall_pct) begin
            push <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= '{char_code: c, end_of_input: eoi};
        do @(posedge i_clk); while (full);
        n_sent++;
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic send_text();
        while (text_buf.size() > 0)
            send_byte(text_buf.pop_front(), 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 3))
            0:       return rand_digit();
            1:       return "_";
            default: return rand_letter();
        endcase
    endfunction

    function automatic string keyword_text(int k);
        case (k)
            0:       return "int";
            1:       return "float";
            2:       return "if";
            3:       return "else";
            4:       return "while";
            5:       return "return";
            default: return "main";
        endcase
    endfunction

    function automatic string operator_text(int k);
        case (k)
            0:  return "<>";
            1:  return "<=";
            2:  return "<";
            3:  return ">=";
            4:  return ">";
            5:  return "==";
            6:  return "=";
            7:  return "++";
            8:  return "+";
            9:  return "--";
            10: return "-";
            11: return "*";
            12: return "%";
            default: return "/";
        endcase
    endfunction

    function automatic string punct_text(int k);
        case (k)
            0:       return "(";
            1:       return ")";
            2:       return ";";
            3:       return "{";
            4:       return "}";
            default: return ",";
        endcase
    endfunction

    // Queue one well-formed token or a piece of noise, or send an end of input, then maybe a random separator
    task automatic add_piece();
        string s;
        int    len;
        case ($urandom_range(0, 15))
            0, 1: begin
                s = keyword_text($urandom_range(0, 6));
                case ($urandom_range(0, 3))
                    0:       s = s.substr(0, $urandom_range(0, s.len() - 2));
                    1:       add_str("");
                    default: ;
                endcase
                add_str(s);
                if ($urandom_range(0, 3) == 0)
                    text_buf.push_back(rand_word_char());
            end
            2, 3: begin
                len = ($urandom_range(0, 149) == 0) ? $urandom_range(250, 262)
                                                    : $urandom_range(1, 8);
                text_buf.push_back(($urandom_range(0, 5) == 0) ? 8'("_") : rand_letter());
                repeat (len - 1) text_buf.push_back(rand_word_char());
            end
            4: repeat ($urandom_range(1, 6)) text_buf.push_back(rand_digit());
            5: begin
                repeat ($urandom_range(1, 4)) text_buf.push_back(rand_digit());
                add_str(".");
                repeat ($urandom_range(0, 4)) text_buf.push_back(rand_digit());
            end
            6: begin
                repeat ($urandom_range(1, 3)) text_buf.push_back(rand_digit());
                text_buf.push_back(($urandom_range(0, 3) == 0) ? 8'("_") : rand_letter());
                repeat ($urandom_range(0, 4)) text_buf.push_back(rand_word_char());
            end
            7, 8: add_str(operator_text($urandom_range(0, 13)));
            9:    add_str(punct_text($urandom_range(0, 5)));
            10: begin
                add_str("//");
                repeat ($urandom_range(0, 10))
                    text_buf.push_back(8'($urandom_range(0, 255)) ^ 8'h0A ? 8'($urandom_range(11, 255)) : 8'h20);
                if ($urandom_range(0, 5) != 0)
                    text_buf.push_back(8'h0A);
            end
            11: begin
                send_text();
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            12:   text_buf.push_back(8'($urandom_range(0, 255)));
            13:   text_buf.push_back(8'($urandom_range(128, 255)));
            default: text_buf.push_back(($urandom_range(0, 1)) ? 8'h20 : 8'h0A);
        endcase
        case ($urandom_range(0, 5))
            0:       text_buf.push_back(8'h20);
            1:       text_buf.push_back(8'h0A);
            2:       text_buf.push_back(8'h09);
            default: ;
        endcase
    endtask

    // Reset, directed tokens, then random token streams
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every operator but the slash, and a lone less-than
        add_str("*%<><=<a>=>b===++c+--d-");
        send_text();
        // keyword, bad id, number, float, slash, comment, high byte, flush
        add_str("(if 7x 12 3.5/q//z");
        text_buf.push_back(8'h0A);
        text_buf.push_back(8'hFF);
        add_str("main");
        send_text();
        send_byte(8'h00, 1'b1);
        add_str("//open");
        send_text();
        send_byte(8'hFF, 1'b1);

        // words long enough to saturate the length
        text_buf.push_back("w");
        repeat (259) text_buf.push_back(rand_word_char());
        add_str(" 1.");
        repeat (256) text_buf.push_back(rand_digit());
        add_str(";");
        send_text();

        while (n_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 3))
                    0:       send_stall_pct = 0;
                    1:       send_stall_pct = 4;
                    2:       send_stall_pct = 15;
                    default: send_stall_pct = 40;
                endcase
            end
            if (n_sent >= QUIET_FROM)
                quiet = 1'b1;
            add_piece();
            send_text();
        end
        send_byte(8'h00, 1'b1);
        push <= 1'b0;

        // Drain the remaining tokens, then allow for the pipeline
        for (int guard = 0; n_pending != 0 && guard < 2000; guard++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Scanned %0d characters into %0d tokens; %0d characters gave two tokens.",
                 n_sent, n_checked, n_double);
        if (n_errors == 0 && n_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (n_pending != 0)
                $error("%0d expected tokens never came out", n_pending);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/cts_pkg.sv
design/cts_front.sv
design/cts_queue.sv
design/cts_back.sv
design/c_like_token_scanner.sv
sim/cts_checker.sv
sim/tb_c_like_token_scanner.sv
